@@ hdl/ensemble_phase_axial_gradient_assert.svh @@
// Assertion macros used by the gradient stage (epag_grad).
`ifndef ENSEMBLE_PHASE_AXIAL_GRADIENT_ASSERT_SVH
`define ENSEMBLE_PHASE_AXIAL_GRADIENT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define EPAG_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define EPAG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/epag_pkg.sv @@
// Shared constants and types for the phase-gradient estimator.
`timescale 1ns / 1ps
`default_nettype none

package epag_pkg;

    localparam int CFG_W = 7;
    localparam logic [CFG_W-1:0] ENS_LEN_RESET = 7'd8;

    // CORDIC: operands pre-shifted by PRESCALE, angle unit pi = 2^ZPI_EXP
    localparam int PRESCALE = 20;
    localparam int ZPI_EXP  = 30;
    localparam int Z_W      = 32;
    localparam int ATAN_LEN = 28;

    localparam logic signed [Z_W-1:0] Z_PI      = 32'sd1073741824;
    localparam logic signed [Z_W-1:0] Z_HALF_PI = 32'sd536870912;

    // atan(2^-i), pi = 2^30, rounded to nearest
    localparam logic [29:0] ATAN_TABLE [ATAN_LEN] = '{
        30'd268435456, 30'd158466703, 30'd83729454, 30'd42502378,
        30'd21333666,  30'd10677233,  30'd5339919,  30'd2670123,
        30'd1335082,   30'd667543,    30'd333772,   30'd166886,
        30'd83443,     30'd41722,     30'd20861,    30'd10430,
        30'd5215,      30'd2608,      30'd1304,     30'd652,
        30'd326,       30'd163,       30'd81,       30'd41,
        30'd20,        30'd10,        30'd5,        30'd3
    };

    // control that travels with a phase value from the CORDIC to the gradient stage
    typedef struct packed {
        logic valid;
        logic beam_end;
    } t_phase_ctl;

endpackage

`default_nettype wire

@@ hdl/epag_fifo.sv @@
// Small register-based FIFO used for the job and result queues.
`timescale 1ns / 1ps
`default_nettype none

module epag_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             wr, rd;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            unique case ({wr, rd})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/epag_front.sv @@
// Front end: ensemble accumulation, length register and depth-close detection.
`timescale 1ns / 1ps
`default_nettype none

module epag_front #(
    parameter int SAMPLE_BITS  = 16,
    parameter int MAX_ENSEMBLE = 64,
    parameter int SUM_W        = 22
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_accept,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_real,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_imag,
    input  wire logic                          i_beam_end,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [epag_pkg::CFG_W-1:0]    i_cfg_wr_data,
    output logic                               o_job_push,
    output logic signed [SUM_W-1:0]            o_job_real,
    output logic signed [SUM_W-1:0]            o_job_imag,
    output logic                               o_job_end
);

    import epag_pkg::*;

    localparam int CNT_W = $clog2(MAX_ENSEMBLE + 1);
    localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_ENSEMBLE);

    logic [CFG_W-1:0]        r_ens_len;
    logic signed [SUM_W-1:0] r_sum_real, r_sum_imag, n_sum_real, n_sum_imag;
    logic [CNT_W-1:0]        r_count, n_count;
    logic [CMP_W-1:0]        len_ext, len_eff;
    logic                    close;

    always_comb begin
        len_ext = CMP_W'(r_ens_len);
        priority if (len_ext == '0) begin
            len_eff = CMP_W'(1);
        end else if (len_ext > MAX_LEN) begin
            len_eff = MAX_LEN;
        end else begin
            len_eff = len_ext;
        end
        n_sum_real = r_sum_real + SUM_W'(i_sample_real);
        n_sum_imag = r_sum_imag + SUM_W'(i_sample_imag);
        n_count    = r_count + CNT_W'(1);
        // a shortened length closes the depth as soon as the count reaches it
        close      = (CMP_W'(n_count) >= len_eff) || i_beam_end;
    end

    assign o_job_push = i_accept && close;
    assign o_job_real = n_sum_real;
    assign o_job_imag = n_sum_imag;
    assign o_job_end  = i_beam_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ens_len  <= ENS_LEN_RESET;
            r_sum_real <= '0;
            r_sum_imag <= '0;
            r_count    <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_ens_len <= i_cfg_wr_data;
            end
            if (i_accept) begin
                if (close) begin
                    r_sum_real <= '0;
                    r_sum_imag <= '0;
                    r_count    <= '0;
                end else begin
                    r_sum_real <= n_sum_real;
                    r_sum_imag <= n_sum_imag;
                    r_count    <= n_count;
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ hdl/epag_cordic.sv @@
// Pipelined vectoring CORDIC: phase magnitude of an ensemble sum.
`timescale 1ns / 1ps
`default_nettype none

module epag_cordic #(
    parameter int SUM_W      = 22,
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic signed [SUM_W-1:0] i_sum_real,
    input  wire logic signed [SUM_W-1:0] i_sum_imag,
    input  wire logic                    i_end,
    output epag_pkg::t_phase_ctl         o_ctl,
    output logic [ANGLE_BITS-1:0]        o_phase,
    input  wire logic                    i_take
);

    import epag_pkg::*;

    localparam int N   = ANGLE_BITS + 2;
    localparam int X_W = SUM_W + PRESCALE + 2;
    localparam int SH  = ZPI_EXP + 1 - ANGLE_BITS;

    logic signed [X_W-1:0] r_x [N+1];
    logic signed [X_W-1:0] r_y [N+1];
    logic signed [Z_W-1:0] r_z [N+1];
    logic                  r_neg [N+1];
    logic                  r_end [N+1];
    logic [N:0]            r_vld;

    logic                  r_out_vld, r_out_end;
    logic [ANGLE_BITS-1:0] r_phase, n_phase;

    logic                  advance;
    logic signed [X_W-1:0] re_ext, im_ext, abs_re, abs_im;
    logic signed [Z_W-1:0] zc;
    logic [Z_W-1:0]        mag, rnd;

    // whole pipe moves together; it stops only when the output register is stuck
    assign advance = !r_out_vld || i_take;
    assign o_ready = advance;

    always_comb begin
        re_ext = X_W'(i_sum_real);
        im_ext = X_W'(i_sum_imag);
        abs_re = re_ext[X_W-1] ? -re_ext : re_ext;
        abs_im = im_ext[X_W-1] ? -im_ext : im_ext;
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_x[0]   <= abs_re <<< PRESCALE;
            r_y[0]   <= abs_im <<< PRESCALE;
            r_z[0]   <= '0;
            r_neg[0] <= i_sum_real[SUM_W-1];
            r_end[0] <= i_end;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_iter
        logic signed [X_W-1:0] xs, ys, n_x, n_y;
        logic signed [Z_W-1:0] step, n_z;

        always_comb begin
            xs   = r_x[k] >>> k;
            ys   = r_y[k] >>> k;
            step = Z_W'(ATAN_TABLE[k]);
            n_x  = r_x[k];
            n_y  = r_y[k];
            n_z  = r_z[k];
            priority if (r_y[k] > 0) begin
                n_x = r_x[k] + ys;
                n_y = r_y[k] - xs;
                n_z = r_z[k] + step;
            end else if (r_y[k] < 0) begin
                n_x = r_x[k] - ys;
                n_y = r_y[k] + xs;
                n_z = r_z[k] - step;
            end
        end

        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_x[k+1]   <= n_x;
                r_y[k+1]   <= n_y;
                r_z[k+1]   <= n_z;
                r_neg[k+1] <= r_neg[k];
                r_end[k+1] <= r_end[k];
            end
        end
    end

    // clamp to [0, pi/2], mirror for a negative real part, round half up
    always_comb begin
        priority if (r_z[N] < 0) begin
            zc = '0;
        end else if (r_z[N] > Z_HALF_PI) begin
            zc = Z_HALF_PI;
        end else begin
            zc = r_z[N];
        end
        mag     = r_neg[N] ? Z_W'(Z_PI - zc) : Z_W'(zc);
        rnd     = mag + (Z_W'(1) << (SH - 1));
        n_phase = rnd[SH +: ANGLE_BITS];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_vld     <= {r_vld[N-1:0], i_valid};
            r_out_vld <= r_vld[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_phase   <= n_phase;
            r_out_end <= r_end[N];
        end
    end

    assign o_ctl.valid    = r_out_vld;
    assign o_ctl.beam_end = r_out_end;
    assign o_phase        = r_phase;

endmodule

`default_nettype wire

@@ hdl/epag_grad.sv @@
// Back end: depth-to-depth phase difference and end-of-beam repeat.
`timescale 1ns / 1ps
`default_nettype none
`include "ensemble_phase_axial_gradient_assert.svh"

module epag_grad #(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire epag_pkg::t_phase_ctl  i_ctl,
    input  wire logic [ANGLE_BITS-1:0] i_phase,
    output logic                       o_take,
    input  wire logic                  i_res_full,
    output logic                       o_res_push,
    output logic signed [ANGLE_BITS:0] o_res_grad,
    output logic                       o_res_last
);

    import epag_pkg::*;

    typedef enum logic [1:0] {
        DS_NEW,
        DS_ONE,
        DS_MANY
    } t_depth;

    t_depth                    r_depth;
    logic [ANGLE_BITS-1:0]     r_prev_mag;
    logic                      r_sec_vld;
    logic signed [ANGLE_BITS:0] r_sec_grad;
    logic signed [ANGLE_BITS:0] grad;

    // the repeated result has priority; no new phase while it waits
    assign o_take = i_ctl.valid && !r_sec_vld && !i_res_full;
    assign grad   = signed'({1'b0, i_phase}) - signed'({1'b0, r_prev_mag});

    always_comb begin
        priority if (r_sec_vld) begin
            o_res_push = !i_res_full;
            o_res_grad = r_sec_grad;
            o_res_last = 1'b1;
        end else if (o_take && (r_depth == DS_NEW)) begin
            // single-depth beam sends its phase magnitude
            o_res_push = i_ctl.beam_end;
            o_res_grad = signed'({1'b0, i_phase});
            o_res_last = 1'b1;
        end else if (o_take) begin
            o_res_push = 1'b1;
            o_res_grad = grad;
            o_res_last = 1'b0;
        end else begin
            o_res_push = 1'b0;
            o_res_grad = grad;
            o_res_last = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth    <= DS_NEW;
            r_sec_vld  <= 1'b0;
            r_prev_mag <= '0;
        end else begin
            if (r_sec_vld && !i_res_full) begin
                r_sec_vld <= 1'b0;
            end
            if (o_take) begin
                r_prev_mag <= i_phase;
                unique case (r_depth)
                    DS_NEW: begin
                        if (!i_ctl.beam_end) begin
                            r_depth <= DS_ONE;
                        end
                    end
                    DS_ONE, DS_MANY: begin
                        r_sec_grad <= grad;
                        if (i_ctl.beam_end) begin
                            r_sec_vld <= 1'b1;
                            r_depth   <= DS_NEW;
                        end else begin
                            r_depth <= DS_MANY;
                        end
                    end
                    default: r_depth <= DS_NEW;
                endcase
            end
        end
    end

    `EPAG_ASSERT_NEXT(a_beam_end_repeats, i_clk, i_rst_n, o_take && i_ctl.beam_end && (r_depth != DS_NEW), r_sec_vld && (r_depth == DS_NEW), "multi-depth beam end did not queue the repeat")
    `EPAG_ASSERT_NEXT(a_repeat_drains, i_clk, i_rst_n, r_sec_vld && !i_res_full, !r_sec_vld, "repeated result not released after transfer")
    `EPAG_ASSERT_IMPLY(a_no_push_when_full, i_clk, i_rst_n, o_res_push, !i_res_full, "result pushed into a full queue")

endmodule

`default_nettype wire

@@ hdl/ensemble_phase_axial_gradient.sv @@
// Top level of the axial phase-gradient estimator.
// Usage:
//   Input channel is a queue write: a sample transfers on a clock edge with push high
//   and full low. Each sample carries real/imag parts and beam_end (last sample of the
//   beam's last depth). Samples are summed per depth over ensemble_length shots
//   (written through i_cfg_wr_en / i_cfg_wr_data while idle; 0 acts as 1, values above
//   MAX_ENSEMBLE act as MAX_ENSEMBLE). beam_end also closes a short depth early.
//   Result channel is a queue read: while empty is low the oldest phase_gradient and
//   last_of_beam are on the ports; a transfer happens when pop is high.
//   Throughput: one sample per clock while full is low. A beam of D depths gives D results; at the end
//   of a multi-depth beam the repeated difference is sent as an extra result.
//   Path of a closed depth: job queue, CORDIC input register, ANGLE_BITS + 2 CORDIC
//   stages, CORDIC output register, gradient stage and result queue.
//   Structure: accumulator -> 4-entry job queue -> CORDIC pipe -> gradient stage ->
//   4-entry result queue. When pop stays low the result queue fills, the CORDIC pipe
//   stops, the job queue fills and full rises; no data is lost.
//   Reset (synchronous, active low) clears sums, queues and beam state and sets the
//   ensemble length to 8.
`timescale 1ns / 1ps
`default_nettype none

module ensemble_phase_axial_gradient #(
    parameter int SAMPLE_BITS  = 16,
    parameter int MAX_ENSEMBLE = 64,
    parameter int ANGLE_BITS   = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_real,
    input  wire logic signed [SAMPLE_BITS-1:0] i_sample_imag,
    input  wire logic                          i_beam_end,
    output logic                               empty,
    input  wire logic                          pop,
    output logic signed [ANGLE_BITS:0]         o_phase_gradient,
    output logic                               o_last_of_beam,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [epag_pkg::CFG_W-1:0]    i_cfg_wr_data
);

    import epag_pkg::*;

    localparam int SUM_W   = SAMPLE_BITS + $clog2(MAX_ENSEMBLE);
    localparam int JOB_W   = 2 * SUM_W + 1;
    localparam int RES_W   = ANGLE_BITS + 2;
    localparam int Q_DEPTH = 4;

    // front end
    logic                    accept;
    logic                    job_push;
    logic signed [SUM_W-1:0] job_real_in, job_imag_in;
    logic                    job_end_in;

    // job queue
    logic [JOB_W-1:0]        job_q;
    logic                    job_empty;
    logic signed [SUM_W-1:0] job_real, job_imag;
    logic                    job_end;

    // CORDIC / gradient
    logic                    cordic_ready;
    t_phase_ctl              phase_ctl;
    logic [ANGLE_BITS-1:0]   phase;
    logic                    phase_take;

    // result queue
    logic                    res_full, res_push, res_last;
    logic signed [ANGLE_BITS:0] res_grad;
    logic [RES_W-1:0]        res_q;

    assign accept = push && !full;

    epag_front #(
        .SAMPLE_BITS  (SAMPLE_BITS),
        .MAX_ENSEMBLE (MAX_ENSEMBLE),
        .SUM_W        (SUM_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_sample_real (i_sample_real),
        .i_sample_imag (i_sample_imag),
        .i_beam_end    (i_beam_end),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_job_push    (job_push),
        .o_job_real    (job_real_in),
        .o_job_imag    (job_imag_in),
        .o_job_end     (job_end_in)
    );

    // closed depths wait here; full back-pressures the sample input
    epag_fifo #(
        .WIDTH (JOB_W),
        .DEPTH (Q_DEPTH)
    ) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  ({job_end_in, job_imag_in, job_real_in}),
        .o_full  (full),
        .i_pop   (cordic_ready),
        .o_data  (job_q),
        .o_empty (job_empty)
    );

    assign job_real = job_q[SUM_W-1:0];
    assign job_imag = job_q[2*SUM_W-1:SUM_W];
    assign job_end  = job_q[JOB_W-1];

    epag_cordic #(
        .SUM_W      (SUM_W),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (!job_empty),
        .o_ready    (cordic_ready),
        .i_sum_real (job_real),
        .i_sum_imag (job_imag),
        .i_end      (job_end),
        .o_ctl      (phase_ctl),
        .o_phase    (phase),
        .i_take     (phase_take)
    );

    epag_grad #(
        .ANGLE_BITS (ANGLE_BITS)
    ) u_grad (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (phase_ctl),
        .i_phase    (phase),
        .o_take     (phase_take),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res_grad (res_grad),
        .o_res_last (res_last)
    );

    // results wait here for the consumer's pop
    epag_fifo #(
        .WIDTH (RES_W),
        .DEPTH (Q_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  ({res_last, res_grad}),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_q),
        .o_empty (empty)
    );

    assign o_phase_gradient = res_q[ANGLE_BITS:0];
    assign o_last_of_beam   = res_q[RES_W-1];

endmodule

`default_nettype wire

@@ test/tb_ensemble_phase_axial_gradient.sv @@
// Self-checking testbench for the axial phase-gradient estimator.
`timescale 1ns / 1ps

module tb_ensemble_phase_axial_gradient;

    localparam int  HALF_PERIOD = 4;
    localparam int  RESET_CYCLES = 9;
    localparam int  SETTLE_CYCLES = 40;     // comfortably above the pipe latency
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  HOLD_CYCLES = 400;
    localparam int  PHASE_ITEMS = 128;
    localparam int  MAX_LEN = 64;
    localparam int  CORDIC_STEPS = 18;      // angle width + 2
    localparam int  ROUND_SHIFT = 15;       // pi = 2^30 internally, 2^15 at the output
    localparam longint Z_PI = 64'sd1 <<< 30;

    // atan(2^-i) with pi = 2^30, rounded to nearest
    localparam longint ATAN_Z [CORDIC_STEPS] = '{
        268435456, 158466703, 83729454, 42502378, 21333666, 10677233,
        5339919, 2670123, 1335082, 667543, 333772, 166886, 83443, 41722,
        20861, 10430, 5215, 2608
    };

    typedef struct {
        logic [15:0] re;
        logic [15:0] im;
        logic        last;
    } t_sample;

    typedef struct {
        logic signed [16:0] grad;
        logic               last;
    } t_grad;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic push = 1'b0;
    logic full;
    logic signed [15:0] sample_re = '0;
    logic signed [15:0] sample_im = '0;
    logic beam_end = 1'b0;
    logic empty;
    logic pop = 1'b0;
    logic signed [16:0] phase_grad;
    logic last_of_beam;
    logic cfg_wr_en = 1'b0;
    logic [epag_pkg::CFG_W-1:0] cfg_wr_data = '0;

    ensemble_phase_axial_gradient DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .push             (push),
        .full             (full),
        .i_sample_real    (sample_re),
        .i_sample_imag    (sample_im),
        .i_beam_end       (beam_end),
        .empty            (empty),
        .pop              (pop),
        .o_phase_gradient (phase_grad),
        .o_last_of_beam   (last_of_beam),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_wr_data    (cfg_wr_data)
    );

    always #HALF_PERIOD clk = ~clk;

    // samples waiting to be offered, and gradients waiting to come out
    t_sample pending_samples[$];
    t_grad   grad_q[$];

    // predictor state
    logic [6:0] ens_len = epag_pkg::ENS_LEN_RESET;
    longint acc_re = 0;
    longint acc_im = 0;
    int     acc_cnt = 0;
    int     prev_mag = 0;
    longint prev_grad = 0;
    int     depth_state = 0;     // 0 new beam, 1 one depth closed, 2 two or more

    // traffic shaping
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    bit hold_req = 1'b0;
    int tx_gap = 0;
    int rx_gap = 0;
    int hold_left = 0;

    int errors = 0;
    int results_checked = 0;
    int samples_sent = 0;
    int samples_queued = 0;
    int beams_queued = 0;
    int len_settings = 1;
    int cycle_cnt = 0;

    // CORDIC vectoring on the ensemble sum; returns |angle| in units of pi / 2^15
    function automatic int phase_of(longint re, longint im);
        longint x, y, z, xs, ys, m;
        x = (re < 0 ? -re : re) * (64'sd1 <<< 20);
        y = (im < 0 ? -im : im) * (64'sd1 <<< 20);
        z = 0;
        if (re == 0 && im == 0) begin
            return 0;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_Z[i];
            end else if (y < 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_Z[i];
            end
        end
        if (z < 0) z = 0;
        if (z > Z_PI / 2) z = Z_PI / 2;
        m = (re < 0) ? Z_PI - z : z;
        return int'((m + (64'sd1 <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT);
    endfunction

    // advance the predictor by one accepted sample, queue the gradients it causes
    function automatic void accumulate_sample(t_sample s);
        int     eff;
        int     mag;
        longint g;
        t_grad  r;
        eff = (ens_len == 0) ? 1 : ((ens_len > MAX_LEN) ? MAX_LEN : int'(ens_len));
        acc_re  += longint'($signed(s.re));
        acc_im  += longint'($signed(s.im));
        acc_cnt += 1;
        if (acc_cnt < eff && !s.last) begin
            return;
        end
        mag = phase_of(acc_re, acc_im);
        acc_re  = 0;
        acc_im  = 0;
        acc_cnt = 0;
        if (depth_state == 0) begin
            prev_mag = mag;
            if (s.last) begin
                // single-depth beam: its magnitude is the only result
                r.grad = 17'(mag);
                r.last = 1'b1;
                grad_q.push_back(r);
            end else begin
                depth_state = 1;
            end
            return;
        end
        g = longint'(mag) - longint'(prev_mag);
        prev_grad = g;
        prev_mag  = mag;
        r.grad = 17'(g);
        r.last = 1'b0;
        grad_q.push_back(r);
        if (s.last) begin
            // end of beam repeats the last difference
            r.grad = 17'(prev_grad);
            r.last = 1'b1;
            grad_q.push_back(r);
            depth_state = 0;
        end else begin
            depth_state = 2;
        end
    endfunction

    // acceptance, predictor update and result checking, all on the rising edge
    always @(posedge clk) begin
        if (rst_n) begin
            if (cfg_wr_en) begin
                ens_len = cfg_wr_data;
            end
            if (push && !full) begin
                accumulate_sample(pending_samples[0]);
                void'(pending_samples.pop_front());
                samples_sent++;
            end
            if (pop && !empty) begin
                if (grad_q.size() == 0) begin
                    $display("%0t: unexpected result grad=%0d last=%0b", $time,
                             phase_grad, last_of_beam);
                    errors++;
                end else begin
                    if (phase_grad !== grad_q[0].grad) begin
                        $display("%0t: phase_gradient expected %0d actual %0d", $time,
                                 grad_q[0].grad, phase_grad);
                        errors++;
                    end
                    if (last_of_beam !== grad_q[0].last) begin
                        $display("%0t: last_of_beam expected %0b actual %0b", $time,
                                 grad_q[0].last, last_of_beam);
                        errors++;
                    end
                    void'(grad_q.pop_front());
                    results_checked++;
                end
            end
        end
    end

    // sample driver: offers the head of the pending queue, with random idle bursts
    always @(negedge clk) begin
        if (!rst_n) begin
            push <= 1'b0;
        end else if (tx_gap > 0) begin
            tx_gap--;
            push <= 1'b0;
        end else if (pending_samples.size() > 0) begin
            push      <= 1'b1;
            sample_re <= pending_samples[0].re;
            sample_im <= pending_samples[0].im;
            beam_end  <= pending_samples[0].last;
            if (tx_idle_en && $urandom_range(0, 11) == 0) begin
                tx_gap = $urandom_range(1, 16);
            end
        end else begin
            push <= 1'b0;
        end
    end

    // result receiver: random stalls, plus one long hold-off to back up the pipe
    always @(negedge clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (!rst_n) begin
            pop <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            pop <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--;
            pop <= 1'b0;
        end else begin
            pop <= 1'b1;
            if (rx_idle_en && $urandom_range(0, 9) == 0) begin
                rx_gap = $urandom_range(1, 16);
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout: %0d results still expected", grad_q.size());
            $display("ensemble_phase_axial_gradient test failed");
            $finish;
        end
    end

    task automatic add_sample(logic [15:0] re, logic [15:0] im, logic last);
        t_sample s;
        s.re   = re;
        s.im   = im;
        s.last = last;
        pending_samples.push_back(s);
        samples_queued++;
    endtask

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    // one beam: full depths, last depth possibly cut short by beam_end;
    // now and then a noisy burst with beam_end at random
    task automatic add_beam(int eff);
        int          depths;
        int          n;
        bit          coherent;
        logic [15:0] base_re;
        logic [15:0] base_im;
        beams_queued++;
        if ($urandom_range(0, 9) == 0) begin
            n = $urandom_range(1, 3 * eff);
            for (int k = 0; k < n; k++) begin
                add_sample(pick_value(), pick_value(),
                           (k == n - 1) || ($urandom_range(0, 3) == 0));
            end
            return;
        end
        depths = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, (eff > 16) ? 3 : 6);
        for (int d = 0; d < depths; d++) begin
            n = eff;
            if (d == depths - 1 && $urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, eff);
            end
            coherent = $urandom_range(0, 1);
            base_re  = pick_value();
            base_im  = pick_value();
            for (int k = 0; k < n; k++) begin
                if (coherent) begin
                    add_sample(base_re + 16'($urandom_range(0, 63)) - 16'd32,
                               base_im + 16'($urandom_range(0, 63)) - 16'd32,
                               (d == depths - 1) && (k == n - 1));
                end else begin
                    add_sample(pick_value(), pick_value(), (d == depths - 1) && (k == n - 1));
                end
            end
        end
    endtask

    // everything sent, every result back, then time for a depth with no result to clear
    task automatic wait_drained();
        while (pending_samples.size() > 0 || grad_q.size() > 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_length(logic [6:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        len_settings++;
    endtask

    initial begin
        logic [6:0] lengths [9];
        int         eff;
        int         start;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed, reset length of 8
        @(posedge clk);
        // one-depth beam closed early by beam_end
        add_sample(16'h7fff, 16'h0000, 1'b0);
        add_sample(16'h7fff, 16'h0000, 1'b0);
        add_sample(16'h0000, 16'h8000, 1'b1);
        // one-depth beam whose sum is zero
        add_sample(16'd5, -16'sd3, 1'b0);
        add_sample(-16'sd5, 16'd3, 1'b1);
        // full depth of most-negative samples, then a short last depth
        for (int k = 0; k < 8; k++) begin
            add_sample(16'h8000, 16'h8000, 1'b0);
        end
        add_sample(16'h8000, 16'h7fff, 1'b1);
        wait_drained();

        // length 0 acts as 1: swing between angle 0 and pi for the extreme gradients
        write_length(7'd0);
        @(posedge clk);
        add_sample(16'h0001, 16'h0000, 1'b0);
        add_sample(16'h8000, 16'h0000, 1'b0);
        add_sample(16'h0001, 16'h0000, 1'b1);
        add_sample(16'h7fff, 16'h7fff, 1'b0);
        add_sample(16'h0000, 16'h0000, 1'b0);
        add_sample(16'hffff, 16'h8000, 1'b1);
        add_sample(16'h8000, 16'h8000, 1'b1);
        wait_drained();

        // random phases; 127 clamps to 64, and the tail of a phase may leave a
        // depth partly filled so the next length takes over mid-depth
        lengths = '{7'd1, 7'd2, 7'd127, 7'd3, 7'd64, 7'd6,
                    7'($urandom_range(1, 12)), 7'($urandom_range(1, 12)), 7'd8};
        foreach (lengths[p]) begin
            write_length(lengths[p]);
            eff = (lengths[p] == 0) ? 1 : ((lengths[p] > MAX_LEN) ? MAX_LEN : lengths[p]);
            tx_idle_en = (p != 0) && (p < 7);
            rx_idle_en = (p < 7);
            @(posedge clk);
            if (p == 0) begin
                // receiver holds off while the sender keeps pushing, so full rises
                hold_req = 1'b1;
            end
            start = samples_queued;
            while (samples_queued - start < PHASE_ITEMS) begin
                add_beam(eff);
            end
            if (eff > 1 && $urandom_range(0, 1) == 1) begin
                repeat ($urandom_range(1, eff - 1)) add_sample(pick_value(), pick_value(), 1'b0);
            end
            wait_drained();
        end

        $display("%0d samples in %0d beams, %0d length settings including clamps to 1 and 64",
                 samples_sent, beams_queued, len_settings);
        $display("%0d results checked, %0d mismatches", results_checked, errors);
        if (errors == 0) begin
            $display("ensemble_phase_axial_gradient test passed");
        end else begin
            $display("ensemble_phase_axial_gradient test failed");
        end
        $finish;
    end

endmodule
